// ===== src/stli_pkg.sv =====
package stli_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] key;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ===== src/stli_if.sv =====
interface stli_in_if;
  logic               valid;
  logic               ready;
  stli_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stli_out_if;
  logic                valid;
  logic                ready;
  stli_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/stli_ram.sv =====
module stli_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/sorted_table_linear_interpolator.sv =====
// Piecewise-linear lookup table of up to TABLE_DEPTH (key, value) breakpoints
// kept in ascending key order in one key/value RAM with a registered read.
// One item is handled at a time: the next transfer is taken only after the
// previous result has been accepted, so a stalled output also stalls the input.
// A clear, an ignored action, a load into a full table and a query on an empty
// table go straight to the result. A load compares entries from the top
// downward, shifting each larger entry up one place (one RAM read, then the
// compare and the shift write per entry compared), then writes the new entry.
// A query scans upward, reading one entry at a time, until it finds an equal
// key or the bracketing pair. An exact hit or an out-of-range key ends the
// query there; an interpolation then runs a 33-step restoring divider that
// divides (key - a0)*(c1 - c0) by (a1 - a0) to get the offset from c0.
module sorted_table_linear_interpolator #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  stli_in_if.sink          in_i,
  stli_out_if.source       out_o
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_CHK, S_LD_PUT, S_Q_RD, S_Q_CHK, S_DIV, S_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic signed [15:0] key_q, val_q;
  logic signed [15:0] a0_q, c0_q;
  logic               have0_q;
  logic               busy_q;
  logic               ov_q;
  logic signed [15:0] res_q;
  logic [1:0]         st_q;
  // Divider: |num| up to 2^32, |den| < 2^17.
  logic [32:0]        rem_q;
  logic [32:0]        quo_q;
  logic [16:0]        den_q;
  logic               neg_q;
  logic [5:0]         dcnt_q;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;

  stli_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic signed [15:0] rk, rv;
  assign rk = rdata[31:16];
  assign rv = rdata[15:0];

  assign in_i.ready = !busy_q && !ov_q;
  assign out_o.valid = ov_q;
  assign out_o.data.result_value = res_q;
  assign out_o.data.status = st_q;

  logic [CW-1:0] idxm1;
  assign idxm1 = idx_q - CW'(1);

  // Query interpolation terms.
  logic signed [16:0] dx, dc, da;
  logic signed [33:0] prod;
  assign dx = 17'(key_q) - 17'(a0_q);
  assign dc = 17'(rv) - 17'(c0_q);
  assign da = 17'(rk) - 17'(a0_q);
  assign prod = 34'(dx) * 34'(dc);

  logic [33:0] trial;
  assign trial = {rem_q, quo_q[32]} - {17'd0, den_q};

  always_comb begin
    we = 1'b0;
    waddr = idxm1[AW-1:0];
    wdata = {key_q, val_q};
    raddr = idx_q[AW-1:0];
    case (state_q)
      S_LD_RD: raddr = idxm1[AW-1:0];
      S_LD_CHK: begin
        if (rk > key_q) begin
          we = 1'b1;
          waddr = idx_q[AW-1:0];
          wdata = rdata;
        end
      end
      S_LD_PUT: begin
        we = 1'b1;
        waddr = idx_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      busy_q <= 1'b0;
      ov_q <= 1'b0;
      idx_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (out_o.valid && out_o.ready) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            key_q <= in_i.data.key;
            val_q <= in_i.data.value;
            res_q <= '0;
            st_q <= stli_pkg::ST_OK;
            busy_q <= 1'b1;
            state_q <= S_DONE;
            case (stli_pkg::action_e'(in_i.data.action))
              stli_pkg::ACT_CLEAR: count_q <= '0;
              stli_pkg::ACT_LOAD: begin
                if (count_q >= CW'(TABLE_DEPTH)) begin
                  st_q <= stli_pkg::ST_FULL;
                end else begin
                  idx_q <= count_q;
                  state_q <= (count_q == '0) ? S_LD_PUT : S_LD_RD;
                end
              end
              stli_pkg::ACT_QUERY: begin
                if (count_q == '0) begin
                  st_q <= stli_pkg::ST_EMPTY;
                end else begin
                  idx_q <= '0;
                  have0_q <= 1'b0;
                  state_q <= S_Q_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_LD_RD: state_q <= S_LD_CHK;
        S_LD_CHK: begin
          // Entry idx-1 is in rdata; shift it up if strictly greater.
          if (rk > key_q) begin
            idx_q <= idxm1;
            state_q <= (idxm1 == '0) ? S_LD_PUT : S_LD_RD;
          end else begin
            state_q <= S_LD_PUT;
          end
        end
        S_LD_PUT: begin
          count_q <= count_q + CW'(1);
          state_q <= S_DONE;
        end
        S_Q_RD: state_q <= S_Q_CHK;
        S_Q_CHK: begin
          if (rk == key_q) begin
            res_q <= rv;
            state_q <= S_DONE;
          end else if (rk > key_q) begin
            if (!have0_q) begin
              st_q <= stli_pkg::ST_RANGE;
              state_q <= S_DONE;
            end else begin
              neg_q <= prod[33];
              quo_q <= prod[33] ? 33'(-prod) : prod[32:0];
              rem_q <= '0;
              den_q <= da[16:0];
              dcnt_q <= 6'd33;
              state_q <= S_DIV;
            end
          end else begin
            a0_q <= rk;
            c0_q <= rv;
            have0_q <= 1'b1;
            if (idx_q + CW'(1) == count_q) begin
              st_q <= stli_pkg::ST_RANGE;
              state_q <= S_DONE;
            end else begin
              idx_q <= idx_q + CW'(1);
              state_q <= S_Q_RD;
            end
          end
        end
        S_DIV: begin
          if (dcnt_q == '0) begin
            res_q <= c0_q + (neg_q ? -quo_q[15:0] : quo_q[15:0]);
            state_q <= S_DONE;
          end else begin
            dcnt_q <= dcnt_q - 6'd1;
            if (!trial[33]) begin
              rem_q <= trial[32:0];
              quo_q <= {quo_q[31:0], 1'b1};
            end else begin
              rem_q <= {rem_q[31:0], quo_q[32]};
              quo_q <= {quo_q[31:0], 1'b0};
            end
          end
        end
        S_DONE: begin
          if (!ov_q || out_o.ready) begin
            ov_q <= 1'b1;
            busy_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/stli_checker.sv =====
module stli_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic [1:0] in_action_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [15:0] out_value_i,
  input logic [1:0] out_status_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_value_i) && $stable(out_status_i))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != stli_pkg::ST_OK |-> out_value_i == 16'd0)
    else $error("flagged result carries a value");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transfer taken while busy");
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == stli_pkg::ACT_CLEAR |=>
      ##1 out_valid_i && out_status_i == stli_pkg::ST_OK)
    else $error("clear not answered");
endmodule

bind sorted_table_linear_interpolator stli_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready), .in_action_i(in_i.data.action),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .out_value_i(out_o.data.result_value), .out_status_i(out_o.data.status)
);
